### rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types and decode codes of the banked mapper with scanline irq.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    // chr bank registers
    localparam int CHR_BANK_COUNT = 8;
    localparam int CHR_BANK_IDX_W = $clog2(CHR_BANK_COUNT);

    // item kinds
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // register window, address bits 15-12
    localparam logic [3:0] SEL_PRG_FIRST  = 4'h8;
    localparam logic [3:0] SEL_MIRROR     = 4'h9;
    localparam logic [3:0] SEL_PRG_SECOND = 4'hA;
    localparam logic [3:0] SEL_CHR_B      = 4'hB;
    localparam logic [3:0] SEL_CHR_C      = 4'hC;
    localparam logic [3:0] SEL_CHR_D      = 4'hD;
    localparam logic [3:0] SEL_CHR_E      = 4'hE;
    localparam logic [3:0] SEL_IRQ        = 4'hF;

    // offsets inside the mirroring window, address bits 3-0
    localparam logic [3:0] MIR_OFS_MODE = 4'h0;
    localparam logic [3:0] MIR_OFS_SWAP = 4'h2;

    // offsets inside the irq window, address bits 1-0
    localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL  = 2'd2;
    localparam logic [1:0] IRQ_ACK      = 2'd3;

    localparam logic [7:0] IRQ_COUNT_TOP = 8'hFF;

    // one accepted item as seen by the register blocks
    typedef struct packed
    {
        logic        write;
        logic        tick;
        logic [15:0] address;
        logic [7:0]  data;
    } bus_cmd_t;

    // mapper registers after an item
    typedef struct packed
    {
        logic [7:0]                          prg_first;
        logic [7:0]                          prg_second;
        logic                                swap;
        logic [1:0]                          mirror;
        logic [CHR_BANK_COUNT-1:0][7:0]      chr;
    } bank_state_t;

    // one result item
    typedef struct packed
    {
        logic [7:0]  prg_bank_first;
        logic [7:0]  prg_bank_second;
        logic        prg_window_swapped;
        logic [1:0]  mirroring_mode;
        logic [63:0] chr_banks_packed;
        logic        irq_pulse;
    } out_item_t;

endpackage

### rtl/bmsi_in_if.sv
// ----------------------------------------------------------------------------
// bmsi_in_if
// Input channel: cpu writes and scanline ticks, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmsi_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source
    (
        output valid,
        output operation,
        output bus_address,
        output write_data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  operation,
        input  bus_address,
        input  write_data,
        output ready
    );
endinterface

### rtl/bmsi_out_if.sv
// ----------------------------------------------------------------------------
// bmsi_out_if
// Result channel: mapper state after each item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmsi_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  prg_bank_first;
    logic [7:0]  prg_bank_second;
    logic        prg_window_swapped;
    logic [1:0]  mirroring_mode;
    logic [63:0] chr_banks_packed;
    logic        irq_pulse;

    modport source
    (
        output valid,
        output prg_bank_first,
        output prg_bank_second,
        output prg_window_swapped,
        output mirroring_mode,
        output chr_banks_packed,
        output irq_pulse,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  prg_bank_first,
        input  prg_bank_second,
        input  prg_window_swapped,
        input  mirroring_mode,
        input  chr_banks_packed,
        input  irq_pulse,
        output ready
    );
endinterface

### rtl/bmsi_bank_regs.sv
// ----------------------------------------------------------------------------
// bmsi_bank_regs
// PRG, CHR, mirroring and swap registers with the cpu write decode.
// ----------------------------------------------------------------------------
module bmsi_bank_regs
    import bmsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bus_cmd_t    cmd,
    output bank_state_t state_next
);

    bank_state_t               state_reg;
    logic [3:0]                sel;
    logic [CHR_BANK_IDX_W-1:0] chr_idx;

    assign sel     = cmd.address[15:12];
    assign chr_idx = {sel[1:0] + 2'd1, cmd.address[1]};

    // write decode
    always_comb
    begin
        state_next = state_reg;
        if (cmd.write)
        begin
            case (sel)
                SEL_PRG_FIRST:  state_next.prg_first  = cmd.data;
                SEL_PRG_SECOND: state_next.prg_second = cmd.data;
                SEL_MIRROR:
                begin
                    case (cmd.address[3:0])
                        MIR_OFS_MODE: state_next.mirror = cmd.data[1:0];
                        MIR_OFS_SWAP: state_next.swap   = cmd.data[1];
                        default:      state_next = state_reg;
                    endcase
                end
                SEL_CHR_B, SEL_CHR_C, SEL_CHR_D, SEL_CHR_E:
                begin
                    // even address takes the high nibble, odd the low nibble
                    if (cmd.address[0])
                        state_next.chr[chr_idx][3:0] = cmd.data[3:0];
                    else
                        state_next.chr[chr_idx][7:4] = cmd.data[3:0];
                end
                default: state_next = state_reg;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/bmsi_irq_counter.sv
// ----------------------------------------------------------------------------
// bmsi_irq_counter
// Scanline irq counter with reload latch, enable bits and acknowledge.
// ----------------------------------------------------------------------------
module bmsi_irq_counter
    import bmsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bus_cmd_t cmd,
    output logic     pulse
);

    logic [7:0] reload_reg;
    logic [7:0] reload_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [1:0] enable_reg;
    logic [1:0] enable_next;

    // register writes and tick counting
    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        enable_next = enable_reg;
        pulse       = 1'b0;
        if (cmd.write && (cmd.address[15:12] == SEL_IRQ))
        begin
            case (cmd.address[1:0])
                IRQ_LATCH_LO: reload_next[3:0] = cmd.data[3:0];
                IRQ_LATCH_HI: reload_next[7:4] = cmd.data[3:0];
                IRQ_CONTROL:
                begin
                    enable_next = cmd.data[1:0];
                    if (cmd.data[1])
                        count_next = reload_reg - 8'd1;
                end
                IRQ_ACK:      enable_next = {enable_reg[0], enable_reg[0]};
                default:      enable_next = enable_reg;
            endcase
        end
        if (cmd.tick && enable_reg[1])
        begin
            if (count_reg == IRQ_COUNT_TOP)
            begin
                count_next = reload_reg + 8'd1;
                pulse      = 1'b1;
            end
            else
            begin
                count_next = count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            count_reg  <= '0;
            enable_reg <= '0;
        end
        else
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            enable_reg <= enable_next;
        end
    end

endmodule

### rtl/bmsi_out_skid.sv
// ----------------------------------------------------------------------------
// bmsi_out_skid
// Result register with a skid stage, so input ready is a register output.
// ----------------------------------------------------------------------------
module bmsi_out_skid
    import bmsi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      push_ready,
    output logic      pop_valid,
    input  logic      pop_ready,
    output out_item_t pop_item
);

    logic      main_valid_reg;
    logic      main_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t main_item_reg;
    out_item_t main_item_next;
    out_item_t skid_item_reg;
    out_item_t skid_item_next;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_item   = main_item_reg;

    // refill the result register from the skid stage first, then from the input
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_item_next  = main_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (!main_valid_reg || pop_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

### rtl/banked_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// banked_mapper_with_scanline_irq
// Cartridge bank mapper with a scanline irq counter.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: operation 0 is a cpu register write
//   (bus_address, write_data), operation 1 is a scanline tick.
//   result carries one item per cmd item, in order: the PRG banks, the swap
//   bit, the mirroring mode, the eight CHR banks as they stand after that
//   item, and irq_pulse, set on the tick that wraps the irq counter.
//   The result is registered: an accepted item has its result valid right
//   after it unless result stalls; one item per cycle is sustained while taken.
//   The register update and the result are formed in one pass of decode
//   logic between the accept and the result register.
//   A stalled result channel: the result register plus one skid stage hold
//   two results; cmd.ready drops once both are full and comes back the
//   cycle after result takes one.
//   Reset clears every mapper and irq register and drops all pending results.
// ----------------------------------------------------------------------------
module banked_mapper_with_scanline_irq
    import bmsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bmsi_in_if.sink     cmd,
    bmsi_out_if.source  result
);

    logic        accept;
    logic        push_ready;
    logic        pulse;
    bus_cmd_t    bus_cmd;
    bank_state_t bank_next;
    out_item_t   push_item;
    out_item_t   pop_item;

    // accepted item
    assign cmd.ready       = push_ready;
    assign accept          = cmd.valid && push_ready;
    assign bus_cmd.write   = accept && (cmd.operation == OP_WRITE);
    assign bus_cmd.tick    = accept && (cmd.operation == OP_TICK);
    assign bus_cmd.address = cmd.bus_address;
    assign bus_cmd.data    = cmd.write_data;

    bmsi_bank_regs u_bank_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bus_cmd),
        .state_next (bank_next)
    );

    bmsi_irq_counter u_irq_counter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bus_cmd),
        .pulse (pulse)
    );

    // result item
    assign push_item.prg_bank_first     = bank_next.prg_first;
    assign push_item.prg_bank_second    = bank_next.prg_second;
    assign push_item.prg_window_swapped = bank_next.swap;
    assign push_item.mirroring_mode     = bank_next.mirror;
    assign push_item.chr_banks_packed   = bank_next.chr;
    assign push_item.irq_pulse          = pulse;

    bmsi_out_skid u_out_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (result.valid),
        .pop_ready  (result.ready),
        .pop_item   (pop_item)
    );

    assign result.prg_bank_first     = pop_item.prg_bank_first;
    assign result.prg_bank_second    = pop_item.prg_bank_second;
    assign result.prg_window_swapped = pop_item.prg_window_swapped;
    assign result.mirroring_mode     = pop_item.mirroring_mode;
    assign result.chr_banks_packed   = pop_item.chr_banks_packed;
    assign result.irq_pulse          = pop_item.irq_pulse;

endmodule

### tb/banked_mapper_with_scanline_irq_tb.sv
// ----------------------------------------------------------------------------
// banked_mapper_with_scanline_irq_tb
// Self-checking bench for the banked mapper: drives cpu writes and scanline
// ticks with random gaps and result stalls, predicts the bank and irq state
// after every item and checks each result item field by field.
// ----------------------------------------------------------------------------
module banked_mapper_with_scanline_irq_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmsi_pkg::*;

    logic clk;
    logic rst_n;

    bmsi_in_if  cmd_if();
    bmsi_out_if result_if();

    banked_mapper_with_scanline_irq i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (result_if)
    );

    // predicted mapper state
    logic [7:0] prg_bank_q [2];
    logic [7:0] chr_bank_q [CHR_BANK_COUNT];
    logic [1:0] mirror_q;
    logic       swap_q;
    logic [7:0] irq_latch_q;
    logic [7:0] irq_counter_q;
    logic [1:0] irq_enables_q;

    out_item_t expected_states[$];
    int        fail_count;
    int        counted_items;
    bit        burst_mode;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // idle or stall length for one item, none while bursting
    function automatic int draw_wait();
        return burst_mode ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            note_failure($sformatf("%s expected %h, got %h", name, want, got));
        end
    endtask

    // update the predicted state with one item and queue its result
    task automatic predict_mapper_item(input op_t op, input logic [15:0] addr,
                                       input logic [7:0] data);
        out_item_t  res;
        logic [1:0] pair;
        logic [2:0] idx;
        logic       pulse;
        pulse = 1'b0;
        if (op == OP_TICK)
        begin
            // counting only while enable bit 1 is set
            if (irq_enables_q[1])
            begin
                if (irq_counter_q == IRQ_COUNT_TOP)
                begin
                    irq_counter_q = irq_latch_q + 8'd1;
                    pulse = 1'b1;
                end
                else
                begin
                    irq_counter_q = irq_counter_q + 8'd1;
                end
            end
        end
        else
        begin
            case (addr[15:12])
                SEL_PRG_FIRST:  prg_bank_q[0] = data;
                SEL_PRG_SECOND: prg_bank_q[1] = data;
                SEL_MIRROR:
                begin
                    if (addr[3:0] == MIR_OFS_MODE)
                    begin
                        mirror_q = data[1:0];
                    end
                    else if (addr[3:0] == MIR_OFS_SWAP)
                    begin
                        swap_q = data[1];
                    end
                end
                SEL_CHR_B, SEL_CHR_C, SEL_CHR_D, SEL_CHR_E:
                begin
                    // register pair from the window, bit 1 picks the one
                    pair = addr[13:12] + 2'd1;
                    idx  = {pair, addr[1]};
                    if (!addr[0])
                    begin
                        chr_bank_q[idx][7:4] = data[3:0];
                    end
                    else
                    begin
                        chr_bank_q[idx][3:0] = data[3:0];
                    end
                end
                SEL_IRQ:
                begin
                    case (addr[1:0])
                        IRQ_LATCH_LO: irq_latch_q[3:0] = data[3:0];
                        IRQ_LATCH_HI: irq_latch_q[7:4] = data[3:0];
                        IRQ_CONTROL:
                        begin
                            irq_enables_q = data[1:0];
                            if (data[1])
                            begin
                                irq_counter_q = irq_latch_q - 8'd1;
                            end
                        end
                        IRQ_ACK:      irq_enables_q[1] = irq_enables_q[0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        res.prg_bank_first     = prg_bank_q[0];
        res.prg_bank_second    = prg_bank_q[1];
        res.prg_window_swapped = swap_q;
        res.mirroring_mode     = mirror_q;
        for (int i = 0; i < CHR_BANK_COUNT; i++)
        begin
            res.chr_banks_packed[8*i +: 8] = chr_bank_q[i];
        end
        res.irq_pulse = pulse;
        expected_states.push_back(res);
    endtask

    // send one item, returns at the edge where it is taken
    task automatic send_item(input op_t op, input logic [15:0] addr,
                             input logic [7:0] data);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= op;
        cmd_if.bus_address <= addr;
        cmd_if.write_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_if.ready);
        predict_mapper_item(op, addr, data);
        if (op == OP_TICK || addr[15])
        begin
            counted_items++;
        end
    endtask

    // stop sending and wait until every expected result is in
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_states.size() != 0);
    endtask

    // prg banks, mirroring, swap bit and the ignored writes
    task automatic test_bank_regs();
        send_item(OP_WRITE, {SEL_PRG_FIRST, 12'h000}, 8'hFF);
        send_item(OP_WRITE, {SEL_PRG_SECOND, 12'hFFF}, 8'hFF);
        send_item(OP_WRITE, {SEL_PRG_FIRST, 12'hFFF}, 8'h00);
        for (int m = 0; m < 4; m++)
        begin
            send_item(OP_WRITE, {SEL_MIRROR, 8'h00, MIR_OFS_MODE}, 8'hFC | 8'(m));
        end
        send_item(OP_WRITE, {SEL_MIRROR, 8'hFF, MIR_OFS_SWAP}, 8'h02);
        // unused mirroring offset and low address change nothing
        send_item(OP_WRITE, {SEL_MIRROR, 8'hFF, 4'hF}, 8'hFF);
        send_item(OP_WRITE, 16'h7FFF, 8'hFF);
        send_item(OP_WRITE, {SEL_MIRROR, 8'h00, MIR_OFS_SWAP}, 8'hFD);
    endtask

    // every chr register once, high nibble on even, low nibble on odd
    task automatic test_chr_nibbles();
        logic [3:0] sel;
        for (int w = 0; w < 4; w++)
        begin
            sel = SEL_CHR_B + 4'(w);
            send_item(OP_WRITE, {sel, 12'h000}, 8'h5A);
            send_item(OP_WRITE, {sel, 12'hFF3}, 8'hA5);
        end
    endtask

    // latch, enable, overflow, acknowledge, tick while disabled
    task automatic test_irq_counter();
        send_item(OP_TICK, 16'hFFFF, 8'hFF);
        send_item(OP_WRITE, {SEL_IRQ, 10'h000, IRQ_LATCH_LO}, 8'hFF);
        send_item(OP_WRITE, {SEL_IRQ, 10'h3FF, IRQ_LATCH_HI}, 8'hFF);
        send_item(OP_WRITE, {SEL_IRQ, 10'h000, IRQ_CONTROL}, 8'h02);
        send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_WRITE, {SEL_IRQ, 10'h000, IRQ_CONTROL}, 8'h01);
        send_item(OP_TICK, 16'h0000, 8'h00);
        send_item(OP_WRITE, {SEL_IRQ, 10'h000, IRQ_ACK}, 8'h00);
        send_item(OP_TICK, 16'h0000, 8'h00);
    endtask

    // one random cpu write, mostly inside the register windows
    task automatic send_random_write();
        logic [15:0] addr;
        addr = 16'($urandom);
        if ($urandom_range(0, 7) != 0)
        begin
            addr[15] = 1'b1;
        end
        if (addr[15:12] == SEL_MIRROR && $urandom_range(0, 1) == 0)
        begin
            addr[3:0] = $urandom_range(0, 1) ? MIR_OFS_MODE : MIR_OFS_SWAP;
        end
        send_item(OP_WRITE, addr, 8'($urandom));
    endtask

    // latch setup, enable, then a run of ticks with some acknowledges
    task automatic send_irq_sequence();
        logic [7:0] data;
        int         ticks;
        send_item(OP_WRITE, {SEL_IRQ, 10'($urandom), IRQ_LATCH_LO}, 8'($urandom));
        data = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            data[3:0] = 4'hF;
        end
        send_item(OP_WRITE, {SEL_IRQ, 10'($urandom), IRQ_LATCH_HI}, data);
        data = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
        begin
            data[1] = 1'b1;
        end
        send_item(OP_WRITE, {SEL_IRQ, 10'($urandom), IRQ_CONTROL}, data);
        ticks = $urandom_range(1, 20);
        for (int t = 0; t < ticks; t++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(OP_WRITE, {SEL_IRQ, 10'($urandom), IRQ_ACK}, 8'($urandom));
            end
            else
            begin
                send_item(OP_TICK, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // mixed random traffic with bursts and full drains
    task automatic test_random_traffic();
        int target;
        int kind;
        target = counted_items + 400;
        while (counted_items < target)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 7)
            begin
                send_irq_sequence();
            end
            else if (kind < 16)
            begin
                send_random_write();
            end
            else if (kind < 18)
            begin
                send_item(OP_TICK, 16'($urandom), 8'($urandom));
            end
            else if (kind == 18)
            begin
                burst_mode = !burst_mode;
            end
            else
            begin
                drain_results();
            end
        end
        burst_mode = 1'b0;
    endtask

    // result side: random stalls, compare with the oldest prediction
    initial
    begin : result_checker
        out_item_t got;
        out_item_t want;
        int        stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got.prg_bank_first     = result_if.prg_bank_first;
                got.prg_bank_second    = result_if.prg_bank_second;
                got.prg_window_swapped = result_if.prg_window_swapped;
                got.mirroring_mode     = result_if.mirroring_mode;
                got.chr_banks_packed   = result_if.chr_banks_packed;
                got.irq_pulse          = result_if.irq_pulse;
                if (expected_states.size() == 0)
                begin
                    note_failure($sformatf("result item with nothing expected: %h", got));
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("prg_bank_first", 64'(want.prg_bank_first),
                                64'(got.prg_bank_first));
                    check_field("prg_bank_second", 64'(want.prg_bank_second),
                                64'(got.prg_bank_second));
                    check_field("prg_window_swapped", 64'(want.prg_window_swapped),
                                64'(got.prg_window_swapped));
                    check_field("mirroring_mode", 64'(want.mirroring_mode),
                                64'(got.mirroring_mode));
                    check_field("chr_banks_packed", want.chr_banks_packed,
                                got.chr_banks_packed);
                    check_field("irq_pulse", 64'(want.irq_pulse), 64'(got.irq_pulse));
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // main sequence
    initial
    begin
        fail_count    = 0;
        counted_items = 0;
        burst_mode    = 1'b0;
        prg_bank_q[0] = '0;
        prg_bank_q[1] = '0;
        foreach (chr_bank_q[i])
        begin
            chr_bank_q[i] = '0;
        end
        mirror_q      = '0;
        swap_q        = 1'b0;
        irq_latch_q   = '0;
        irq_counter_q = '0;
        irq_enables_q = '0;

        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.operation   <= OP_WRITE;
        cmd_if.bus_address <= '0;
        cmd_if.write_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_bank_regs();
        test_chr_nibbles();
        test_irq_counter();
        drain_results();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_states.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### banked_mapper_with_scanline_irq.f
rtl/bmsi_pkg.sv
rtl/bmsi_in_if.sv
rtl/bmsi_out_if.sv
rtl/bmsi_bank_regs.sv
rtl/bmsi_irq_counter.sv
rtl/bmsi_out_skid.sv
rtl/banked_mapper_with_scanline_irq.sv
tb/banked_mapper_with_scanline_irq_tb.sv
